FILE: hdl/mrlwp_pkg.sv
package mrlwp_pkg;

	// Result status codes.
	localparam logic [2:0] ST_NULL     = 3'd0;
	localparam logic [2:0] ST_NO_FIT   = 3'd1;
	localparam logic [2:0] ST_BUSY     = 3'd2;
	localparam logic [2:0] ST_LOCKED   = 3'd3;
	localparam logic [2:0] ST_UNLOCKED = 3'd4;
	localparam logic [2:0] ST_WIPED    = 3'd5;

	// Request modes.
	localparam logic MODE_LOCK = 1'b0;
	localparam logic MODE_WIPE = 1'b1;

	// Execute-never, read-only, write-back without write-allocate, shareable, enabled.
	localparam logic [31:0] RASR_ATTR = (32'd1 << 28) | (32'd6 << 24) | (32'd1 << 18)
		| (32'd1 << 17) | (32'd1 << 16) | 32'd1;

	// Search bounds: region sizes of 2^5 up to 2^31 bytes.
	localparam logic [4:0] FIT_FIRST_BITS = 5'd5;
	localparam logic [4:0] FIT_LAST_BITS  = 5'd31;
	localparam logic [31:0] FIT_FIRST_MASK = ~32'h1F;
	localparam logic [31:0] FIT_FIRST_SIZE = 32'd32;

	typedef struct packed {
		logic        done;
		logic        ok;
		logic [31:0] base;
		logic [4:0]  size_field;
	} fit_rsp_t;

endpackage

FILE: hdl/mpu_region_lock_and_wipe_planner.sv
// Channel   Direction  Handshake                 Payload
// config    in         cfg_valid / cfg_ready     region_number
// request   in         in_valid / in_stall       mode, address, length
// result    out        out_valid / out_stall     status, mpu_write, rbar_value, rasr_value,
//                                                prefix_bytes, word_count, tail_bytes
//
// A null or wipe request goes from accept through the PREP state to the OUT state; a lock request
// goes from PREP through SEARCH, where the shared add-and-compare unit tries the candidate
// region sizes in turn (up to 27), and then to OUT. in_stall is high from accept until the result
// transfers, so the next request is accepted only after the previous result has transferred.
// The result is held in output registers while out_stall is high.
// arst_n clears the sequencer, the lock slot and region_number; cfg_ready is always high.

module mpu_region_lock_and_wipe_planner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  region_number,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] address,
	input  logic [31:0] length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        mpu_write,
	output logic [31:0] rbar_value,
	output logic [31:0] rasr_value,
	output logic [1:0]  prefix_bytes,
	output logic [29:0] word_count,
	output logic [1:0]  tail_bytes
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_PREP   = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;
	localparam logic [1:0] S_OUT    = 2'd3;

	logic [1:0]  state_q;
	logic [2:0]  region_q;
	logic        slot_q;
	logic [31:0] locked_addr_q;
	logic [31:0] locked_len_q;
	logic [31:0] locked_base_q;

	logic        mode_q;
	logic [31:0] addr_q;
	logic [31:0] len_q;

	logic [2:0]  status_q;
	logic        wr_q;
	logic [31:0] rbar_q;
	logic [31:0] rasr_q;
	logic [1:0]  prefix_q;
	logic [29:0] words_q;
	logic [1:0]  tail_q;

	logic                in_xfer;
	logic                out_xfer;
	logic                null_req;
	logic                match;
	logic [1:0]          prefix;
	logic [31:0]         mid;
	logic                fit_start;
	mrlwp_pkg::fit_rsp_t fit_rsp;

	assign cfg_ready = 1'b1;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid && !out_stall;

	assign null_req  = (addr_q == 32'd0) || (len_q == 32'd0);
	assign match     = slot_q && (locked_addr_q == addr_q) && (locked_len_q == len_q);
	assign fit_start = (state_q == S_PREP) && !null_req && (mode_q == mrlwp_pkg::MODE_LOCK);

	// Bytes up to word alignment, clamped when the range is shorter than that.
	always_comb begin
		prefix = 2'd0 - addr_q[1:0];
		if ({30'd0, prefix} > len_q) begin
			prefix = len_q[1:0];
		end
		mid = len_q - {30'd0, prefix};
	end

	mrlwp_fit u_fit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fit_start),
		.addr   (addr_q),
		.len    (len_q),
		.rsp    (fit_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			region_q <= region_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			slot_q        <= 1'b0;
			locked_addr_q <= 32'd0;
			locked_len_q  <= 32'd0;
			locked_base_q <= 32'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (fit_start) begin
						state_q <= S_SEARCH;
					end else begin
						state_q <= S_OUT;
						if (!null_req && match) begin
							slot_q <= 1'b0;
						end
					end
				end
				S_SEARCH: begin
					if (fit_rsp.done) begin
						state_q <= S_OUT;
						if (fit_rsp.ok && !slot_q) begin
							slot_q        <= 1'b1;
							locked_addr_q <= addr_q;
							locked_len_q  <= len_q;
							locked_base_q <= fit_rsp.base;
						end
					end
				end
				S_OUT: begin
					if (out_xfer) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= mode;
			addr_q <= address;
			len_q  <= length;
		end
	end

	// Result registers; every field is written on the path that finishes a request.
	always_ff @(posedge clk) begin
		if (state_q == S_PREP && !fit_start) begin
			status_q <= mrlwp_pkg::ST_NULL;
			wr_q     <= 1'b0;
			rbar_q   <= 32'd0;
			rasr_q   <= 32'd0;
			prefix_q <= 2'd0;
			words_q  <= 30'd0;
			tail_q   <= 2'd0;
			if (!null_req) begin
				prefix_q <= prefix;
				words_q  <= mid[31:2];
				tail_q   <= mid[1:0];
				if (match) begin
					status_q <= mrlwp_pkg::ST_UNLOCKED;
					wr_q     <= 1'b1;
					rbar_q   <= {locked_base_q[31:5], 1'b1, 1'b0, region_q};
				end else begin
					status_q <= mrlwp_pkg::ST_WIPED;
				end
			end
		end else if (state_q == S_SEARCH && fit_rsp.done) begin
			wr_q     <= 1'b0;
			rbar_q   <= 32'd0;
			rasr_q   <= 32'd0;
			prefix_q <= 2'd0;
			words_q  <= 30'd0;
			tail_q   <= 2'd0;
			if (!fit_rsp.ok) begin
				status_q <= mrlwp_pkg::ST_NO_FIT;
			end else if (slot_q) begin
				status_q <= mrlwp_pkg::ST_BUSY;
			end else begin
				status_q <= mrlwp_pkg::ST_LOCKED;
				wr_q     <= 1'b1;
				rbar_q   <= {fit_rsp.base[31:5], 1'b1, 1'b0, region_q};
				rasr_q   <= mrlwp_pkg::RASR_ATTR | {26'd0, fit_rsp.size_field, 1'b0};
			end
		end
	end

	assign status       = status_q;
	assign mpu_write    = wr_q;
	assign rbar_value   = rbar_q;
	assign rasr_value   = rasr_q;
	assign prefix_bytes = prefix_q;
	assign word_count   = words_q;
	assign tail_bytes   = tail_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fit_rsp.done |-> (state_q == S_SEARCH))
		else $error("region search finished outside the search state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == mrlwp_pkg::ST_LOCKED || status == mrlwp_pkg::ST_UNLOCKED))
		|-> mpu_write)
		else $error("lock or unlock result without an MPU write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == mrlwp_pkg::ST_LOCKED) |-> slot_q)
		else $error("lock reported but slot is free");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == mrlwp_pkg::ST_UNLOCKED) |-> !slot_q)
		else $error("unlock reported but slot is still held");

endmodule

FILE: hdl/mrlwp_fit.sv
module mrlwp_fit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         addr,
	input  logic [31:0]         len,
	output mrlwp_pkg::fit_rsp_t rsp
);

	logic        busy_q;
	logic [31:0] addr_q;
	logic [32:0] end_q;
	logic [31:0] mask_q;
	logic [31:0] size_q;
	logic [4:0]  bits_q;

	logic [31:0] base;
	logic [32:0] reach;
	logic        hit;
	logic        last;

	// One add and compare per cycle: does the current candidate region reach the range end?
	assign base  = addr_q & mask_q;
	assign reach = {1'b0, base} + {1'b0, size_q};
	assign hit   = reach >= end_q;
	assign last  = bits_q == mrlwp_pkg::FIT_LAST_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (hit || last)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= addr;
			end_q  <= {1'b0, addr} + {1'b0, len};
			mask_q <= mrlwp_pkg::FIT_FIRST_MASK;
			size_q <= mrlwp_pkg::FIT_FIRST_SIZE;
			bits_q <= mrlwp_pkg::FIT_FIRST_BITS;
		end else if (busy_q) begin
			mask_q <= {mask_q[30:0], 1'b0};
			size_q <= {size_q[30:0], 1'b0};
			bits_q <= bits_q + 5'd1;
		end
	end

	always_comb begin
		rsp.done       = busy_q && (hit || last);
		rsp.ok         = hit;
		rsp.base       = base;
		rsp.size_field = bits_q - 5'd1;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (bits_q >= mrlwp_pkg::FIT_FIRST_BITS))
		else $error("fit search ran outside its size range");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot(size_q))
		else $error("fit region size is not a power of two");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !busy_q)
		else $error("fit unit stayed busy after finishing");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam logic [31:0] RBAR_VALID_BIT = 32'h0000_0010;
	localparam logic [31:0] LOCK_ATTR_WORD = 32'h1607_0001;

	typedef struct {
		logic        mode;
		logic [31:0] addr;
		logic [31:0] len;
	} request_t;

	typedef struct {
		logic [2:0]  status;
		logic        wr;
		logic [31:0] rbar;
		logic [31:0] rasr;
		logic [1:0]  prefix;
		logic [29:0] words;
		logic [1:0]  tail;
	} plan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_region = 3'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_mode = 1'b0;
	logic [31:0] req_addr = 32'd0;
	logic [31:0] req_len = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic        mpu_write;
	logic [31:0] rbar_value;
	logic [31:0] rasr_value;
	logic [1:0]  prefix_bytes;
	logic [29:0] word_count;
	logic [1:0]  tail_bytes;

	request_t pending_reqs[$];
	plan_t    expected_plans[$];
	request_t lock_history[$];

	// Predicted block state.
	logic        slot_busy = 1'b0;
	logic [31:0] held_addr = 32'd0;
	logic [31:0] held_len = 32'd0;
	logic [31:0] held_base = 32'd0;
	logic [2:0]  region_sel = 3'd0;

	int unsigned snd_idle_pct = 8;
	int unsigned rcv_idle_pct = 61;
	int unsigned n_taken = 0;
	int unsigned n_bad = 0;
	int unsigned hold_left = 0;
	logic        hold_used = 1'b0;

	mpu_region_lock_and_wipe_planner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.region_number(cfg_region),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (req_mode),
		.address      (req_addr),
		.length       (req_len),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.mpu_write    (mpu_write),
		.rbar_value   (rbar_value),
		.rasr_value   (rasr_value),
		.prefix_bytes (prefix_bytes),
		.word_count   (word_count),
		.tail_bytes   (tail_bytes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	function automatic plan_t plan_request(request_t r);
		plan_t       p;
		logic [32:0] stop;
		logic [32:0] span;
		logic [32:0] lo;
		logic [31:0] base;
		logic [31:0] pre;
		logic [31:0] mid;
		logic [4:0]  sz;
		logic        hit;
		p = '{status: mrlwp_pkg::ST_NULL, wr: 1'b0, rbar: '0, rasr: '0,
			prefix: '0, words: '0, tail: '0};
		base = '0;
		sz = '0;
		hit = 1'b0;
		if (r.addr != 32'd0 && r.len != 32'd0) begin
			if (r.mode == mrlwp_pkg::MODE_LOCK) begin
				// Compare in 33 bits so that a range running past the top never wraps.
				stop = {1'b0, r.addr} + {1'b0, r.len};
				for (int k = 5; k <= 31 && !hit; k++) begin
					span = 33'd1 << k;
					lo = {1'b0, r.addr} & ~(span - 33'd1);
					if (lo + span >= stop) begin
						hit = 1'b1;
						base = lo[31:0];
						sz = 5'(k - 1);
					end
				end
				if (!hit) begin
					p.status = mrlwp_pkg::ST_NO_FIT;
				end else if (slot_busy) begin
					p.status = mrlwp_pkg::ST_BUSY;
				end else begin
					slot_busy = 1'b1;
					held_addr = r.addr;
					held_len = r.len;
					held_base = base;
					p.status = mrlwp_pkg::ST_LOCKED;
					p.wr = 1'b1;
					p.rbar = (base & ~32'h1F) | RBAR_VALID_BIT | {29'd0, region_sel};
					p.rasr = LOCK_ATTR_WORD | {26'd0, sz, 1'b0};
				end
			end else begin
				if (slot_busy && held_addr == r.addr && held_len == r.len) begin
					slot_busy = 1'b0;
					p.status = mrlwp_pkg::ST_UNLOCKED;
					p.wr = 1'b1;
					p.rbar = (held_base & ~32'h1F) | RBAR_VALID_BIT | {29'd0, region_sel};
				end else begin
					p.status = mrlwp_pkg::ST_WIPED;
				end
				pre = (32'd4 - {30'd0, r.addr[1:0]}) & 32'd3;
				if (pre > r.len) begin
					pre = r.len;
				end
				mid = r.len - pre;
				p.prefix = pre[1:0];
				p.words = mid[31:2];
				p.tail = mid[1:0];
			end
		end
		return p;
	endfunction

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			n_bad++;
			if (n_bad <= 10) begin
				$display("mismatch in %s: expected %h, actual %h", name, want, got);
			end
		end
	endtask

	// Request driver: a new request is offered only when the line is free or the
	// previous transfer has just completed.
	always @(posedge clk) begin : req_driver
		logic took;
		took = in_valid && !in_stall;
		if (took) begin
			expected_plans.push_back(plan_request(pending_reqs.pop_front()));
			n_taken <= n_taken + 1;
		end
		if (!in_valid || took) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				req_mode <= pending_reqs[0].mode;
				req_addr <= pending_reqs[0].addr;
				req_len <= pending_reqs[0].len;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side stall, with one long hold-off so the block backs up its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_used && n_taken >= 60) begin
			hold_used <= 1'b1;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_monitor
		plan_t want;
		if (out_valid && !out_stall) begin
			if (expected_plans.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) begin
					$display("result with no request outstanding: status %0d", status);
				end
			end else begin
				want = expected_plans.pop_front();
				check_field("status", 32'(status), 32'(want.status));
				check_field("mpu_write", 32'(mpu_write), 32'(want.wr));
				check_field("rbar_value", rbar_value, want.rbar);
				check_field("rasr_value", rasr_value, want.rasr);
				check_field("prefix_bytes", 32'(prefix_bytes), 32'(want.prefix));
				check_field("word_count", 32'(word_count), 32'(want.words));
				check_field("tail_bytes", 32'(tail_bytes), 32'(want.tail));
			end
		end
	end

	task automatic add_req(logic m, logic [31:0] a, logic [31:0] l);
		pending_reqs.push_back('{mode: m, addr: a, len: l});
		if (m == mrlwp_pkg::MODE_LOCK) begin
			lock_history.push_back('{mode: m, addr: a, len: l});
			if (lock_history.size() > 4) begin
				void'(lock_history.pop_front());
			end
		end
	endtask

	// Wait until every request has been taken and every result has come back.
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || expected_plans.size() != 0 || in_valid);
	endtask

	task automatic write_region(logic [2:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_region <= v;
		do @(negedge clk);
		while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		region_sel = v;
	endtask

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(1, 255);
			2: return 32'hFFFF_FF00 | $urandom_range(0, 255);
			3: return $urandom & ~32'h1F;
			4: return 32'h8000_0000 + $urandom_range(0, 64) - 32;
			default: return 32'd1 << $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic [31:0] pick_len();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 6) return $urandom_range(1, 64);
		if (sel < 12) return $urandom_range(1, 4096);
		if (sel < 15) return $urandom;
		if (sel < 19) return 32'd1 << $urandom_range(0, 31);
		return 32'd0;
	endfunction

	task automatic random_burst(int unsigned n);
		int unsigned cnt;
		int unsigned pick;
		logic [31:0] a;
		logic [31:0] l;
		request_t    h;
		cnt = 0;
		while (cnt < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// Lock then release the same range, with up to two stray requests between.
				a = pick_addr();
				l = pick_len();
				add_req(mrlwp_pkg::MODE_LOCK, a, l);
				cnt++;
				repeat ($urandom_range(0, 2)) begin
					add_req(logic'($urandom_range(0, 1)), pick_addr(), pick_len());
					cnt++;
				end
				add_req(mrlwp_pkg::MODE_WIPE, a, l);
				cnt++;
			end else if (pick < 65 && lock_history.size() != 0) begin
				h = lock_history[$urandom_range(0, lock_history.size() - 1)];
				add_req(mrlwp_pkg::MODE_WIPE, h.addr, h.len);
				cnt++;
			end else if (pick < 72 && lock_history.size() != 0) begin
				// Near miss: one bit off in the address or the length.
				h = lock_history[$urandom_range(0, lock_history.size() - 1)];
				if ($urandom_range(0, 1) != 0) begin
					h.len ^= 32'd1 << $urandom_range(0, 31);
				end else begin
					h.addr ^= 32'd1 << $urandom_range(0, 31);
				end
				add_req(mrlwp_pkg::MODE_WIPE, h.addr, h.len);
				cnt++;
			end else begin
				add_req(logic'($urandom_range(0, 1)), pick_addr(), pick_len());
				cnt++;
			end
		end
	endtask

	initial begin : stimulus
		int unsigned region_plan[7] = '{7, 5, 6, 1, 2, 4, 3};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_region(3'd0);

		add_req(mrlwp_pkg::MODE_LOCK, 32'd0, 32'd16);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h100, 32'd0);
		add_req(mrlwp_pkg::MODE_LOCK, 32'h8000_0000, 32'h8000_0000);
		add_req(mrlwp_pkg::MODE_LOCK, 32'h1000, 32'd4);
		add_req(mrlwp_pkg::MODE_LOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h8000_0000, 32'h7FFF_FFFF);
		wait_quiet();
		// The disable words must carry the region number in force at the wipe.
		write_region(3'd7);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h8000_0000, 32'h8000_0000);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h3, 32'd1);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h1, 32'd2);
		add_req(mrlwp_pkg::MODE_LOCK, 32'h1, 32'd1);
		add_req(mrlwp_pkg::MODE_LOCK, 32'hFFFF_FFF0, 32'h20);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h1, 32'd1);
		add_req(mrlwp_pkg::MODE_LOCK, 32'h7FFF_FFF0, 32'h20);
		add_req(mrlwp_pkg::MODE_LOCK, 32'hFFFF_FFFF, 32'd1);
		add_req(mrlwp_pkg::MODE_WIPE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(mrlwp_pkg::MODE_WIPE, 32'hFFFF_FFFF, 32'd1);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h4, 32'hFFFF_FFFF);
		add_req(mrlwp_pkg::MODE_LOCK, 32'h1, 32'hFFFF_FFFE);
		add_req(mrlwp_pkg::MODE_LOCK, 32'h10, 32'h7FFF_FFF0);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h10, 32'h7FFF_FFF1);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h14, 32'h7FFF_FFF0);
		add_req(mrlwp_pkg::MODE_WIPE, 32'h10, 32'h7FFF_FFF0);

		for (int c = 0; c < 7; c++) begin
			wait_quiet();
			if (c == 2) begin
				snd_idle_pct = 61;
				rcv_idle_pct = 8;
			end else if (c == 5) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			write_region(3'(region_plan[c]));
			random_burst(205);
		end

		wait_quiet();
		repeat (40) @(negedge clk);
		if (n_bad == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
